/* hw/rtl/edd_pkg.sv */
// edd_pkg: shared sizes, register indexes and types of the error diffusion dither
// used by edd_line_buffer, edd_diffuse and error_diffusion_dither; depends on nothing
`default_nettype none

package edd_pkg;

    localparam int MaxWidth   = 256;
    localparam int MaxHeight  = 4096;

    localparam int ColW       = $clog2(MaxWidth);
    localparam int RowW       = $clog2(MaxHeight);
    localparam int ErrW       = 12;
    localparam int AccW       = 11;
    localparam int PixW       = 8;

    localparam int WidthRegW  = 9;
    localparam int HeightRegW = 13;
    localparam int ThrRegW    = 8;
    localparam int CfgDataW   = 13;
    localparam int CfgIdxW    = 2;

    localparam logic [CfgIdxW-1:0] CfgImageWidth     = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgImageHeight    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgWhiteThreshold = 2'd2;

    typedef struct packed {
        logic                   en;
        logic [ColW-1:0]        addr;
        logic signed [ErrW-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic signed [ErrW-1:0] e7;
        logic signed [ErrW-1:0] e5;
        logic signed [ErrW-1:0] e3;
        logic signed [ErrW-1:0] e1;
    } shares_t;

endpackage

`default_nettype wire

/* hw/rtl/edd_line_buffer.sv */
// edd_line_buffer: error memory for the next row, one write and one registered read a cycle
// forwards a write made in the same cycle as the read address; depends on edd_pkg
`default_nettype none

module edd_line_buffer (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire edd_pkg::wr_req_t                        wr,
    input  wire logic [edd_pkg::ColW-1:0]                rd_addr,
    output logic signed [edd_pkg::ErrW-1:0]              rd_data
);

    logic signed [edd_pkg::ErrW-1:0] err_mem_reg [edd_pkg::MaxWidth];
    logic signed [edd_pkg::ErrW-1:0] rd_q_reg;
    logic signed [edd_pkg::ErrW-1:0] byp_data_reg;
    logic                            byp_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            err_mem_reg[wr.addr] <= wr.data;
        end
        rd_q_reg     <= err_mem_reg[rd_addr];
        byp_data_reg <= wr.data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_data = byp_valid_reg ? byp_data_reg : rd_q_reg;

endmodule

`default_nettype wire

/* hw/rtl/edd_diffuse.sv */
// edd_diffuse: accumulate, saturate, threshold and split the quantization error
// combinational datapath of one pixel; depends on edd_pkg
`default_nettype none

module edd_diffuse (
    input  wire logic [edd_pkg::PixW-1:0]          gray,
    input  wire logic signed [edd_pkg::ErrW-1:0]   carry,
    input  wire logic signed [edd_pkg::ErrW-1:0]   above,
    input  wire logic [edd_pkg::ThrRegW-1:0]       threshold,
    output logic                                   white,
    output edd_pkg::shares_t                       shares
);

    localparam int SumW  = edd_pkg::ErrW + 1;
    localparam int ProdW = edd_pkg::ErrW + 4;

    localparam logic signed [SumW-1:0] AccMax = SumW'(1023);
    localparam logic signed [SumW-1:0] AccMin = -SumW'(1024);
    localparam logic signed [edd_pkg::ErrW-1:0] LevelWhite = edd_pkg::ErrW'(255);

    logic signed [SumW-1:0]          sum;
    logic signed [edd_pkg::AccW-1:0] acc;
    logic signed [edd_pkg::ErrW-1:0] err;

    function automatic logic signed [edd_pkg::ErrW-1:0] share(
        input logic signed [edd_pkg::ErrW-1:0] e,
        input logic [2:0]                      w
    );
        logic signed [ProdW-1:0] p;
        p = $signed({{4{e[edd_pkg::ErrW-1]}}, e}) * $signed({(ProdW-3)'(0), w});
        if (p[ProdW-1]) begin
            p = p + ProdW'(15);
        end
        return edd_pkg::ErrW'(p >>> 4);
    endfunction

    always_comb begin
        sum = $signed({(SumW-edd_pkg::PixW)'(0), gray})
            + SumW'(carry) + SumW'(above);
        if (sum > AccMax) begin
            acc = edd_pkg::AccW'(AccMax);
        end else if (sum < AccMin) begin
            acc = edd_pkg::AccW'(AccMin);
        end else begin
            acc = edd_pkg::AccW'(sum);
        end
        white = acc >= $signed({(edd_pkg::AccW-edd_pkg::ThrRegW)'(0), threshold});
        err   = edd_pkg::ErrW'(acc) - (white ? LevelWhite : edd_pkg::ErrW'(0));
        shares.e7 = share(err, 3'd7);
        shares.e5 = share(err, 3'd5);
        shares.e3 = share(err, 3'd3);
        shares.e1 = share(err, 3'd1);
    end

endmodule

`default_nettype wire

/* hw/rtl/error_diffusion_dither.sv */
// error_diffusion_dither: Floyd-Steinberg dither of an 8-bit gray raster to one bit per pixel
// result registered the cycle after its input beat; 1 pixel per cycle when output not stalled
// the line buffer read for the next column is issued the cycle before, with write forwarding
// reset clears position, carried errors, pending write and the output beat
// configuration resets to width 128, height 128, threshold 128; line buffer is not cleared
`default_nettype none

module error_diffusion_dither (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [edd_pkg::CfgIdxW-1:0]      cfg_index,
    input  wire logic [edd_pkg::CfgDataW-1:0]     cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [edd_pkg::PixW-1:0]         s_gray_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_white_bit,
    output logic                                  m_end_of_row,
    output logic                                  m_end_of_frame
);

    localparam int ErrW = edd_pkg::ErrW;
    localparam int ColW = edd_pkg::ColW;
    localparam int RowW = edd_pkg::RowW;
    localparam int WW   = edd_pkg::WidthRegW;
    localparam int HW   = edd_pkg::HeightRegW;

    logic [WW-1:0]                  width_reg;
    logic [HW-1:0]                  height_reg;
    logic [edd_pkg::ThrRegW-1:0]    thr_reg;

    logic [ColW-1:0]                col_reg, col_next;
    logic [RowW-1:0]                row_reg, row_next;
    logic signed [ErrW-1:0]         carry_reg, carry_next;
    logic signed [ErrW-1:0]         below_reg, below_next;
    logic signed [ErrW-1:0]         below_left_reg, below_left_next;
    edd_pkg::wr_req_t               pend_reg, pend_next;

    logic                           m_valid_reg;
    logic                           white_reg, eor_reg, eof_reg;

    logic [WW-1:0]                  w_eff;
    logic [HW-1:0]                  h_eff;
    logic                           first_col, last_col, first_row, last_row;
    logic                           s_fire;
    logic signed [ErrW-1:0]         lb_rd_data, above;
    logic signed [ErrW-1:0]         bl_sum;
    logic                           white;
    edd_pkg::shares_t               shares;
    edd_pkg::wr_req_t               wr;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (width_reg > WW'(edd_pkg::MaxWidth)) begin
            w_eff = WW'(edd_pkg::MaxWidth);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (height_reg > HW'(edd_pkg::MaxHeight)) begin
            h_eff = HW'(edd_pkg::MaxHeight);
        end else begin
            h_eff = height_reg;
        end
    end

    assign first_col = (col_reg == '0);
    assign last_col  = ((WW'(col_reg) + WW'(1)) >= w_eff);
    assign first_row = (row_reg == '0);
    assign last_row  = ((HW'(row_reg) + HW'(1)) >= h_eff);

    assign above = first_row ? ErrW'(0) : lb_rd_data;

    edd_diffuse u_diffuse (
        .gray      (s_gray_value),
        .carry     (carry_reg),
        .above     (above),
        .threshold (thr_reg),
        .white     (white),
        .shares    (shares)
    );

    assign bl_sum = below_reg + shares.e5;

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        carry_next      = carry_reg;
        below_next      = below_reg;
        below_left_next = below_left_reg;
        pend_next       = '0;
        wr              = pend_reg;
        if (s_fire) begin
            if (!last_row && !first_col) begin
                wr.en   = 1'b1;
                wr.addr = col_reg - ColW'(1);
                wr.data = below_left_reg + shares.e3;
            end else if (!last_row && last_col) begin
                wr.en   = 1'b1;
                wr.addr = col_reg;
                wr.data = bl_sum;
            end
            if (!last_row && last_col && !first_col) begin
                pend_next.en   = 1'b1;
                pend_next.addr = col_reg;
                pend_next.data = bl_sum;
            end
            if (last_col) begin
                col_next        = '0;
                row_next        = last_row ? '0 : row_reg + RowW'(1);
                carry_next      = '0;
                below_next      = '0;
                below_left_next = '0;
            end else begin
                col_next        = col_reg + ColW'(1);
                carry_next      = shares.e7;
                below_next      = shares.e1;
                below_left_next = bl_sum;
            end
        end
    end

    edd_line_buffer u_line_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (col_next),
        .rd_data (lb_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(128);
            height_reg <= HW'(128);
            thr_reg    <= edd_pkg::ThrRegW'(128);
        end else if (cfg_we) begin
            unique case (cfg_index)
                edd_pkg::CfgImageWidth:     width_reg  <= cfg_data[WW-1:0];
                edd_pkg::CfgImageHeight:    height_reg <= cfg_data[HW-1:0];
                edd_pkg::CfgWhiteThreshold: thr_reg    <= cfg_data[edd_pkg::ThrRegW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            carry_reg      <= '0;
            below_reg      <= '0;
            below_left_reg <= '0;
            pend_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            carry_reg      <= carry_next;
            below_reg      <= below_next;
            below_left_reg <= below_left_next;
            pend_reg       <= pend_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            white_reg <= white;
            eor_reg   <= last_col;
            eof_reg   <= last_col && last_row;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_white_bit    = white_reg;
    assign m_end_of_row   = eor_reg;
    assign m_end_of_frame = eof_reg;

endmodule

`default_nettype wire

/* hw/rtl/edd_checker.sv */
// edd_checker: port-level assertions for error_diffusion_dither, bound to the top level
// sees only the top level's handshake and result ports
`default_nettype none

module edd_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_white_bit,
    input wire logic m_end_of_row,
    input wire logic m_end_of_frame
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_white_bit)
            && $stable(m_end_of_row) && $stable(m_end_of_frame))
        else $error("result beat changed while stalled");

    a_frame_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_end_of_frame || m_end_of_row)
        else $error("end of frame without end of row");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result waiting");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted beat gave no result");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);

`default_nettype wire
